@@ rtl/gsd_pkg.sv @@
// gsd_pkg: shared types, constants and helpers for the gyro straight-drive sequencer
// depends on nothing; imported by every module under rtl/

package gsd_pkg;

  // heading accumulator width and the divisor from sum to whole heading units
  localparam int HEADING_W       = 32;
  localparam int HEADING_DIVISOR = 50;

  // reciprocal for the truncating divide: q = (mag * DIV_MULT) >> DIV_K, mag < 2**(HEADING_W-1)
  localparam int DIV_LOG = $clog2(HEADING_DIVISOR);
  localparam int DIV_K   = HEADING_W - 1 + DIV_LOG;
  localparam longint unsigned DIV_MULT_L =
    ((64'd1 << DIV_K) + HEADING_DIVISOR - 1) / HEADING_DIVISOR;
  localparam logic [HEADING_W-1:0] DIV_MULT = DIV_MULT_L[HEADING_W-1:0];

  // quotient width and a working width that can hold the heading clamp
  localparam int QW = HEADING_W - DIV_LOG;
  localparam int QX = (QW > 10) ? QW : 10;

  // beyond these magnitudes the side powers saturate the same way
  localparam int H_LIM    = 511;
  localparam int CORR_LIM = 511;

  // motor power limit
  localparam int PWR_LIM = 100;

  // timers
  localparam int TIMER_W = 17;

  // reported heading sum
  localparam int SUM_W = 32;
  localparam int EXT_W = ((HEADING_W > SUM_W) ? HEADING_W : SUM_W) + 1;
  localparam logic signed [EXT_W-1:0] SUM_MAX = EXT_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] SUM_MIN = -SUM_MAX - EXT_W'(64'sd1);

  // run phases as seen on the result
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_DRIVE  = 3'd2,
    PH_SETTLE = 3'd3,
    PH_DECIDE = 3'd4,
    PH_SPIN   = 3'd5
  } phase_t;

  // which motor command a tick produces
  typedef enum logic [1:0] {
    PK_ZERO,
    PK_DRIVE,
    PK_SPIN
  } pwr_kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GYRO_OFFSET  = 3'd0,
    REG_DRIVE_POWER  = 3'd1,
    REG_RUN_TIME     = 3'd2,
    REG_SETTLE_TIME  = 3'd3,
    REG_TICK_PERIOD  = 3'd4,
    REG_CORR_GAIN    = 3'd5
  } cfg_reg_t;

  // per-tick result info carried down the pipeline
  typedef struct packed {
    phase_t                   phase;
    logic                     done;
    pwr_kind_t                kind;
    logic signed [7:0]        spin_rp;
    logic signed [SUM_W-1:0]  heading_sum;
  } tick_info_t;

  // saturate the accumulator to the reported width
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [HEADING_W-1:0] v);
    logic signed [EXT_W-1:0] x;
    logic signed [EXT_W-1:0] y;
    x = EXT_W'(v);
    if (x > SUM_MAX) begin
      y = SUM_MAX;
    end else if (x < SUM_MIN) begin
      y = SUM_MIN;
    end else begin
      y = x;
    end
    return y[SUM_W-1:0];
  endfunction

endpackage

@@ rtl/gsd_seq.sv @@
// gsd_seq: run sequencer, heading integration and timers, one tick per transaction
// depends on gsd_pkg; feeds the heading divider stage

module gsd_seq import gsd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic                        start_req,
  input  logic [9:0]                  gyro_sample,
  input  logic [9:0]                  gyro_offset,
  input  logic signed [7:0]           drive_power,
  input  logic [15:0]                 run_time_ms,
  input  logic [15:0]                 settle_time_ms,
  input  logic [7:0]                  tick_period_ms,
  output logic                        out_vld,
  output tick_info_t                  out_info,
  output logic signed [HEADING_W-1:0] out_acc
);

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic signed [HEADING_W:0] ACC_MAX = {2'b00, {(HEADING_W-1){1'b1}}};
  localparam logic signed [HEADING_W:0] ACC_MIN = {2'b11, {(HEADING_W-1){1'b0}}};

  // run state
  phase_t                   phase_reg;
  logic                     start_seen;
  logic signed [HEADING_W-1:0] heading_acc;
  logic [TIMER_W-1:0]       run_timer;
  logic [TIMER_W-1:0]       settle_timer;
  logic                     spin_right;

  phase_t                   phase_reg_next;
  logic                     start_seen_next;
  logic signed [HEADING_W-1:0] heading_acc_next;
  logic [TIMER_W-1:0]       run_timer_next;
  logic [TIMER_W-1:0]       settle_timer_next;
  logic                     spin_right_next;

  // tick results
  logic                     done;
  pwr_kind_t                kind;
  logic signed [7:0]        spin_rp;

  // working values
  phase_t                   ph;
  logic signed [HEADING_W-1:0] acc;
  logic [TIMER_W-1:0]       rt;
  logic [TIMER_W-1:0]       st;
  logic                     sr;
  logic signed [10:0]       delta;
  logic signed [HEADING_W:0] acc_sum;
  logic signed [8:0]        half;

  wire accept = en && in_vld;

  // saturating timer step
  function automatic logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] t,
                                                    input logic [7:0] p);
    logic [TIMER_W:0] s;
    s = {1'b0, t} + (TIMER_W+1)'(p);
    return (s > {1'b0, TIMER_MAX}) ? TIMER_MAX : s[TIMER_W-1:0];
  endfunction

  // spin power: half of drive power, truncated toward zero
  assign half = ($signed(9'(drive_power)) + $signed({8'd0, drive_power[7]})) >>> 1;

  // next state of the run for this tick
  always_comb begin
    ph  = phase_reg;
    acc = heading_acc;
    rt  = run_timer;
    st  = settle_timer;
    sr  = spin_right;
    start_seen_next = start_seen;

    // a start clears the run and begins with the first wait tick
    if (start_req) begin
      ph  = PH_WAIT;
      acc = '0;
      rt  = '0;
      st  = '0;
      sr  = 1'b0;
      start_seen_next = 1'b0;
    end

    delta   = $signed({1'b0, gyro_sample}) - $signed({1'b0, gyro_offset});
    acc_sum = (HEADING_W+1)'(acc) + (HEADING_W+1)'(delta);

    phase_reg_next    = ph;
    heading_acc_next  = acc;
    run_timer_next    = rt;
    settle_timer_next = st;
    spin_right_next   = sr;
    done = 1'b0;
    kind = PK_ZERO;

    if (ph != PH_IDLE) begin
      // saturating integration
      if (acc_sum > ACC_MAX) begin
        heading_acc_next = ACC_MAX[HEADING_W-1:0];
      end else if (acc_sum < ACC_MIN) begin
        heading_acc_next = ACC_MIN[HEADING_W-1:0];
      end else begin
        heading_acc_next = acc_sum[HEADING_W-1:0];
      end

      case (ph)
        PH_WAIT: begin
          if (!start_seen_next) begin
            start_seen_next = 1'b1;
          end else begin
            phase_reg_next = PH_DRIVE;
          end
        end
        PH_DRIVE: begin
          kind = PK_DRIVE;
          if (rt > {1'b0, run_time_ms}) begin
            phase_reg_next = PH_SETTLE;
            st = '0;
          end
        end
        PH_SETTLE: begin
          if (st > {1'b0, settle_time_ms}) begin
            phase_reg_next = PH_DECIDE;
          end
        end
        PH_DECIDE: begin
          if (heading_acc_next > 0) begin
            spin_right_next = 1'b1;
          end else if (heading_acc_next < 0) begin
            spin_right_next = 1'b0;
          end
          phase_reg_next = PH_SPIN;
        end
        PH_SPIN: begin
          done = sr ? (heading_acc_next > 0) : (heading_acc_next < 0);
          if (done) begin
            phase_reg_next = PH_IDLE;
          end else begin
            kind = PK_SPIN;
          end
        end
        default: begin
          phase_reg_next = ph;
        end
      endcase

      run_timer_next    = timer_add(rt, tick_period_ms);
      settle_timer_next = timer_add(st, tick_period_ms);
    end

    spin_rp = 8'(sr ? -half : half);
  end

  // run state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= PH_IDLE;
      start_seen   <= 1'b0;
      heading_acc  <= '0;
      run_timer    <= '0;
      settle_timer <= '0;
      spin_right   <= 1'b0;
    end else if (accept) begin
      phase_reg    <= phase_reg_next;
      start_seen   <= start_seen_next;
      heading_acc  <= heading_acc_next;
      run_timer    <= run_timer_next;
      settle_timer <= settle_timer_next;
      spin_right   <= spin_right_next;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_info.phase       <= phase_reg_next;
      out_info.done        <= done;
      out_info.kind        <= kind;
      out_info.spin_rp     <= spin_rp;
      out_info.heading_sum <= sat_sum(heading_acc_next);
      out_acc              <= heading_acc_next;
    end
  end

endmodule

@@ rtl/gsd_div.sv @@
// gsd_div: two-stage truncating divide of the heading sum by the heading divisor
// depends on gsd_pkg; output heading is clamped to a range that keeps power math narrow

module gsd_div import gsd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  tick_info_t                  in_info,
  input  logic signed [HEADING_W-1:0] in_acc,
  output logic                        out_vld,
  output tick_info_t                  out_info,
  output logic signed [9:0]           out_heading
);

  localparam int PW = 2 * HEADING_W - 1;

  logic [HEADING_W-1:0] mag;
  logic [HEADING_W-2:0] mag_c;

  // multiply stage
  logic                 mul_vld;
  tick_info_t           mul_info;
  logic                 mul_neg;
  logic [PW-1:0]        mul_prod;

  // quotient and clamp
  logic [QW-1:0]        quot;
  logic [QX-1:0]        quot_x;
  logic [8:0]           h_mag;
  logic signed [9:0]    h_val;

  // magnitude; the most negative sum is taken one smaller, same quotient
  always_comb begin
    mag   = in_acc[HEADING_W-1] ? (~in_acc + 1'b1) : in_acc;
    mag_c = mag[HEADING_W-1] ? {(HEADING_W-1){1'b1}} : mag[HEADING_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      mul_vld <= in_vld;
      out_vld <= mul_vld;
    end
  end

  // reciprocal multiply
  always_ff @(posedge clk) begin
    if (en) begin
      mul_info <= in_info;
      mul_neg  <= in_acc[HEADING_W-1];
      mul_prod <= PW'(mag_c) * PW'(DIV_MULT);
    end
  end

  // shift out the quotient, clamp and restore the sign
  always_comb begin
    quot   = mul_prod[PW-1:DIV_K];
    quot_x = QX'(quot);
    h_mag  = (quot_x > QX'(H_LIM)) ? 9'(H_LIM) : quot_x[8:0];
    h_val  = mul_neg ? -$signed({1'b0, h_mag}) : $signed({1'b0, h_mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_info    <= mul_info;
      out_heading <= h_val;
    end
  end

endmodule

@@ rtl/gsd_pwr.sv @@
// gsd_pwr: heading correction, side power clamp and motor command select
// depends on gsd_pkg; takes the clamped heading from gsd_div

module gsd_pwr import gsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  tick_info_t        in_info,
  input  logic signed [9:0] in_heading,
  input  logic signed [7:0] drive_power,
  input  logic [7:0]        correction_gain,
  output logic              out_vld,
  output tick_info_t        out_info,
  output logic signed [7:0] right_power,
  output logic signed [7:0] left_power
);

  localparam logic signed [18:0] C_HI = 19'(CORR_LIM);
  localparam logic signed [18:0] C_LO = -19'(CORR_LIM);
  localparam logic signed [11:0] P_HI = 12'(PWR_LIM);
  localparam logic signed [11:0] P_LO = -12'(PWR_LIM);

  logic signed [18:0] corr;
  logic signed [9:0]  corr_c;
  logic signed [9:0]  corr_q;

  logic signed [11:0] rp;
  logic signed [11:0] lp;
  logic signed [11:0] hi;
  logic signed [11:0] lo;
  logic signed [11:0] rp_drv;
  logic signed [11:0] lp_drv;

  // correction = heading * gain, clamped
  always_comb begin
    corr = in_heading * $signed({1'b0, correction_gain});
    if (corr > C_HI) begin
      corr_c = 10'(C_HI);
    end else if (corr < C_LO) begin
      corr_c = 10'(C_LO);
    end else begin
      corr_c = corr[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_info <= in_info;
      corr_q   <= corr_c;
    end
  end

  // shift both sides by the excess, then by the deficit, then saturate
  always_comb begin
    rp = 12'(drive_power) + 12'(corr_q);
    lp = 12'(drive_power) - 12'(corr_q);
    hi = (rp > lp) ? rp : lp;
    if (hi > P_HI) begin
      rp = rp - (hi - P_HI);
      lp = lp - (hi - P_HI);
    end
    lo = (rp < lp) ? rp : lp;
    if (lo < P_LO) begin
      rp = rp + (P_LO - lo);
      lp = lp + (P_LO - lo);
    end
    rp_drv = (rp > P_HI) ? P_HI : ((rp < P_LO) ? P_LO : rp);
    lp_drv = (lp > P_HI) ? P_HI : ((lp < P_LO) ? P_LO : lp);
  end

  // command select by tick kind
  always_comb begin
    case (out_info.kind)
      PK_DRIVE: begin
        right_power = rp_drv[7:0];
        left_power  = lp_drv[7:0];
      end
      PK_SPIN: begin
        right_power = out_info.spin_rp;
        left_power  = -out_info.spin_rp;
      end
      default: begin
        right_power = '0;
        left_power  = '0;
      end
    endcase
  end

endmodule

@@ rtl/gyro_straight_drive_sequencer.sv @@
// gyro_straight_drive_sequencer: top level, configuration registers, pipeline control, output
// depends on gsd_pkg, gsd_seq, gsd_div and gsd_pwr
//
// Usage: one input transaction per control tick on the s_ side, s_tdata holding the start
// request and the raw gyro sample. Every tick gives exactly one result transaction on the
// m_ side: right and left motor power, the phase after the tick and the saturated heading
// sum in m_tdata, and m_tlast high on the tick that finishes a run (motors zero, phase idle).
// Configuration registers are to be written through cfg_we / cfg_index / cfg_wdata only
// while no tick is in flight; the block itself does not enforce this. Writes take effect
// at the next clock edge.
// Pipeline: sequencer, reciprocal multiply, quotient, correction multiply, output register.
// Throughput: one tick per cycle while no result is held by m_tready; all five stages move together.
// Stall: while a result waits with m_tready low, the whole pipeline holds and s_tready
// is low; bubbles in the pipeline do not stop the input.
// Reset: rst clears the run to idle, empties the pipeline and restores the register
// defaults (offset 600, power 50, run 1000 ms, settle 150 ms, tick 20 ms, gain 8).

module gyro_straight_drive_sequencer import gsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [0] start_req, [10:1] gyro_sample, [15:11] zero
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // [7:0] right_power, [15:8] left_power, [18:16] phase,
                                  // [50:19] heading_sum, [55:51] zero
  output logic        m_tlast,    // done_res
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  logic [9:0]        gyro_offset;
  logic signed [7:0] drive_power;
  logic [15:0]       run_time_ms;
  logic [15:0]       settle_time_ms;
  logic [7:0]        tick_period_ms;
  logic [7:0]        correction_gain;

  // pipeline
  logic              adv;
  logic              seq_vld;
  tick_info_t        seq_info;
  logic signed [HEADING_W-1:0] seq_acc;
  logic              div_vld;
  tick_info_t        div_info;
  logic signed [9:0] div_heading;
  logic              pwr_vld;
  tick_info_t        pwr_info;
  logic signed [7:0] pwr_right;
  logic signed [7:0] pwr_left;

  // output register
  logic signed [7:0]       rp_q;
  logic signed [7:0]       lp_q;
  phase_t                  phase_q;
  logic                    done_q;
  logic signed [SUM_W-1:0] sum_q;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_offset     <= 10'd600;
      drive_power     <= 8'sd50;
      run_time_ms     <= 16'd1000;
      settle_time_ms  <= 16'd150;
      tick_period_ms  <= 8'd20;
      correction_gain <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GYRO_OFFSET: gyro_offset     <= cfg_wdata[9:0];
        REG_DRIVE_POWER: drive_power     <= cfg_wdata[7:0];
        REG_RUN_TIME:    run_time_ms     <= cfg_wdata;
        REG_SETTLE_TIME: settle_time_ms  <= cfg_wdata;
        REG_TICK_PERIOD: tick_period_ms  <= cfg_wdata[7:0];
        REG_CORR_GAIN:   correction_gain <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline moves whenever the output slot is free or being taken
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  gsd_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .en             (adv),
    .in_vld         (s_tvalid),
    .start_req      (s_tdata[0]),
    .gyro_sample    (s_tdata[10:1]),
    .gyro_offset    (gyro_offset),
    .drive_power    (drive_power),
    .run_time_ms    (run_time_ms),
    .settle_time_ms (settle_time_ms),
    .tick_period_ms (tick_period_ms),
    .out_vld        (seq_vld),
    .out_info       (seq_info),
    .out_acc        (seq_acc)
  );

  gsd_div u_div (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_vld      (seq_vld),
    .in_info     (seq_info),
    .in_acc      (seq_acc),
    .out_vld     (div_vld),
    .out_info    (div_info),
    .out_heading (div_heading)
  );

  gsd_pwr u_pwr (
    .clk             (clk),
    .rst             (rst),
    .en              (adv),
    .in_vld          (div_vld),
    .in_info         (div_info),
    .in_heading      (div_heading),
    .drive_power     (drive_power),
    .correction_gain (correction_gain),
    .out_vld         (pwr_vld),
    .out_info        (pwr_info),
    .right_power     (pwr_right),
    .left_power      (pwr_left)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= pwr_vld;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      rp_q    <= pwr_right;
      lp_q    <= pwr_left;
      phase_q <= pwr_info.phase;
      done_q  <= pwr_info.done;
      sum_q   <= pwr_info.heading_sum;
    end
  end

  assign m_tdata = {5'd0, sum_q, phase_q, lp_q, rp_q};
  assign m_tlast = done_q;

`ifndef ASSERT_OFF
  // a finishing tick stops the motors and returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && done_q |-> rp_q == 8'sd0 && lp_q == 8'sd0 && phase_q == PH_IDLE)
    else $error("done tick with motors running or phase not idle");

  // a held result stalls the input
  a_stall_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  // motor commands stay within limits
  a_power_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rp_q >= -8'sd100 && rp_q <= 8'sd100 && lp_q >= -8'sd100 && lp_q <= 8'sd100)
    else $error("motor power out of range");

  // the first wait tick drives no motor
  a_wait_still: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && phase_q == PH_WAIT |-> rp_q == 8'sd0 && lp_q == 8'sd0 && !done_q)
    else $error("motors driven during start wait");
`endif

endmodule

@@ dv/gsd_checker.sv @@
// gsd_checker: predicts every tick result of the gyro straight-drive sequencer and compares
// each result transaction against it, field by field, in order of arrival
// depends on gsd_pkg; instantiated by tb beside the block

module gsd_checker import gsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,    // [0] start_req, [10:1] gyro_sample, [15:11] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,    // [7:0] right_power, [15:8] left_power, [18:16] phase,
                                  // [50:19] heading_sum, [55:51] zero
  input  logic        m_tlast,    // done_res
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          mismatch_count,
  output int          ticks_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  // register defaults after reset
  localparam int DEF_OFFSET = 600;
  localparam int DEF_POWER  = 50;
  localparam int DEF_RUN    = 1000;
  localparam int DEF_SETTLE = 150;
  localparam int DEF_TICK   = 20;
  localparam int DEF_GAIN   = 8;

  localparam longint HACC_MAX  = (64'sd1 <<< (HEADING_W - 1)) - 64'sd1;
  localparam longint HACC_MIN  = -HACC_MAX - 64'sd1;
  localparam longint SUM_TOP   = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
  localparam longint SUM_BOT   = -SUM_TOP - 64'sd1;
  localparam int     TIMER_CAP = (1 << TIMER_W) - 1;
  localparam int     SHOWN_MAX = 10;

  typedef struct packed {
    logic signed [7:0]       right_pwr;
    logic signed [7:0]       left_pwr;
    phase_t                  phase;
    logic                    done;
    logic signed [SUM_W-1:0] heading_sum;
  } tick_result_t;

  // register copies
  int gyro_ofs, base_pwr, run_lim, settle_lim, tick_ms, corr_gain;

  // run state
  phase_t run_phase;
  logic   start_seen;
  longint heading_acc;
  int     run_timer, settle_timer;
  logic   spin_right;

  tick_result_t tick_results_q[$];
  int           err_total;

  assign mismatch_count = err_total;

  function automatic longint pwr_clamp(input longint v);
    return (v > PWR_LIM) ? PWR_LIM : ((v < -PWR_LIM) ? -PWR_LIM : v);
  endfunction

  function automatic int timer_step(input int t);
    int s;
    s = t + tick_ms;
    return (s > TIMER_CAP) ? TIMER_CAP : s;
  endfunction

  // one control tick of the sequencer
  function automatic tick_result_t run_tick(input logic start, input logic [9:0] sample);
    tick_result_t r;
    longint rp, lp, hi, lo, h, corr, half, shown;
    logic finished;
    rp = 0;
    lp = 0;
    finished = 1'b0;
    if (start) begin
      run_phase = PH_WAIT;
      start_seen = 1'b0;
      heading_acc = 0;
      run_timer = 0;
      settle_timer = 0;
      spin_right = 1'b0;
    end
    if (run_phase != PH_IDLE) begin
      heading_acc = heading_acc + longint'(sample) - longint'(gyro_ofs);
      if (heading_acc > HACC_MAX) heading_acc = HACC_MAX;
      else if (heading_acc < HACC_MIN) heading_acc = HACC_MIN;
      h = heading_acc / HEADING_DIVISOR;
      case (run_phase)
        PH_WAIT: begin
          if (!start_seen) start_seen = 1'b1;
          else run_phase = PH_DRIVE;
        end
        PH_DRIVE: begin
          // both sides shift by the same excess before saturation
          corr = h * corr_gain;
          rp = base_pwr + corr;
          lp = base_pwr - corr;
          hi = (rp > lp) ? rp : lp;
          if (hi > PWR_LIM) begin
            rp = rp - (hi - PWR_LIM);
            lp = lp - (hi - PWR_LIM);
          end
          lo = (rp < lp) ? rp : lp;
          if (lo < -PWR_LIM) begin
            rp = rp + (-PWR_LIM - lo);
            lp = lp + (-PWR_LIM - lo);
          end
          rp = pwr_clamp(rp);
          lp = pwr_clamp(lp);
          if (run_timer > run_lim) begin
            run_phase = PH_SETTLE;
            settle_timer = 0;
          end
        end
        PH_SETTLE: begin
          if (settle_timer > settle_lim) run_phase = PH_DECIDE;
        end
        PH_DECIDE: begin
          // zero heading keeps the previous direction
          if (heading_acc > 0) spin_right = 1'b1;
          else if (heading_acc < 0) spin_right = 1'b0;
          run_phase = PH_SPIN;
        end
        default: begin
          half = base_pwr / 2;
          if (spin_right) begin
            rp = -half;
            lp = half;
            finished = (heading_acc > 0);
          end else begin
            rp = half;
            lp = -half;
            finished = (heading_acc < 0);
          end
          if (finished) begin
            rp = 0;
            lp = 0;
            run_phase = PH_IDLE;
          end
          rp = pwr_clamp(rp);
          lp = pwr_clamp(lp);
        end
      endcase
      run_timer = timer_step(run_timer);
      settle_timer = timer_step(settle_timer);
    end
    shown = (heading_acc > SUM_TOP) ? SUM_TOP : ((heading_acc < SUM_BOT) ? SUM_BOT : heading_acc);
    r.right_pwr = 8'(rp);
    r.left_pwr = 8'(lp);
    r.phase = run_phase;
    r.done = finished;
    r.heading_sum = SUM_W'(shown);
    return r;
  endfunction

  // register writes, tick prediction and result comparison
  always @(posedge clk) begin
    tick_result_t want, got;
    logic bad;
    if (rst) begin
      gyro_ofs = DEF_OFFSET;
      base_pwr = DEF_POWER;
      run_lim = DEF_RUN;
      settle_lim = DEF_SETTLE;
      tick_ms = DEF_TICK;
      corr_gain = DEF_GAIN;
      run_phase = PH_IDLE;
      start_seen = 1'b0;
      heading_acc = 0;
      run_timer = 0;
      settle_timer = 0;
      spin_right = 1'b0;
      tick_results_q.delete();
      err_total = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_GYRO_OFFSET: gyro_ofs = int'(cfg_wdata[9:0]);
          REG_DRIVE_POWER: base_pwr = int'($signed(cfg_wdata[7:0]));
          REG_RUN_TIME:    run_lim = int'(cfg_wdata);
          REG_SETTLE_TIME: settle_lim = int'(cfg_wdata);
          REG_TICK_PERIOD: tick_ms = int'(cfg_wdata[7:0]);
          REG_CORR_GAIN:   corr_gain = int'(cfg_wdata[7:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        tick_results_q.push_back(run_tick(s_tdata[0], s_tdata[10:1]));
      end
      if (m_tvalid && m_tready) begin
        got.right_pwr = m_tdata[7:0];
        got.left_pwr = m_tdata[15:8];
        got.phase = phase_t'(m_tdata[18:16]);
        got.done = m_tlast;
        got.heading_sum = m_tdata[50:19];
        if (tick_results_q.size() == 0) begin
          err_total = err_total + 1;
          if (err_total <= SHOWN_MAX)
            $display("%0t: result with no tick outstanding: rp=%0d lp=%0d ph=%0d done=%0b sum=%0d",
                     $time, got.right_pwr, got.left_pwr, got.phase, got.done, got.heading_sum);
        end else begin
          want = tick_results_q.pop_front();
          bad = (got.right_pwr !== want.right_pwr) || (got.left_pwr !== want.left_pwr) ||
                (got.phase !== want.phase) || (got.done !== want.done) ||
                (got.heading_sum !== want.heading_sum) || (m_tdata[55:51] !== 5'd0);
          if (bad) begin
            err_total = err_total + 1;
            if (err_total <= SHOWN_MAX) begin
              $display("%0t: tick mismatch", $time);
              $display("  exp rp=%0d lp=%0d ph=%0d done=%0b sum=%0d pad=0",
                       want.right_pwr, want.left_pwr, want.phase, want.done, want.heading_sum);
              $display("  got rp=%0d lp=%0d ph=%0d done=%0b sum=%0d pad=%0h",
                       got.right_pwr, got.left_pwr, got.phase, got.done, got.heading_sum,
                       m_tdata[55:51]);
            end
          end
        end
      end
    end
    ticks_in_flight <= tick_results_q.size();
  end

endmodule

@@ dv/tb.sv @@
// tb: stimulus, flow control and verdict for the gyro straight-drive sequencer
// depends on gsd_pkg, the rtl top gyro_straight_drive_sequencer and dv/gsd_checker

module tb import gsd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 10;

  typedef enum int {
    MIX_RX_HEAVY,   // sender idles 36 of 100, receiver 51
    MIX_TX_HEAVY,   // sender idles 51 of 100, receiver 36
    MIX_NONE
  } stall_mix_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int         mismatch_count;
  int         ticks_in_flight;
  int         quiet_cycles = 0;
  int         ticks_sent = 0;
  stall_mix_t stall_mix = MIX_RX_HEAVY;

  // register copies used to size the runs
  int cfg_ofs = 600;
  int cfg_run = 1000;
  int cfg_settle = 150;
  int cfg_tick = 20;

  gyro_straight_drive_sequencer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  gsd_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatch_count), .ticks_in_flight(ticks_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    case (stall_mix)
      MIX_RX_HEAVY: m_tready <= ($urandom_range(0, 99) >= 51);
      MIX_TX_HEAVY: m_tready <= ($urandom_range(0, 99) >= 36);
      default:      m_tready <= 1'b1;
    endcase
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one tick transaction, with random sender gaps ahead of it
  task automatic send_tick(input logic start, input logic [9:0] sample);
    int gap_pct;
    gap_pct = (stall_mix == MIX_RX_HEAVY) ? 36 : ((stall_mix == MIX_TX_HEAVY) ? 51 : 0);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, sample, start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent = ticks_sent + 1;
  endtask

  // hold the sender until every tick result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (ticks_in_flight != 0);
  endtask

  task automatic apply_setting(input int ofs, input int pwr, input int run, input int settle,
                               input int tick, input int gain);
    drain_results();
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_GYRO_OFFSET;
    cfg_wdata <= 16'(ofs);
    @(posedge clk);
    cfg_index <= REG_DRIVE_POWER;
    cfg_wdata <= {8'd0, 8'(pwr)};
    @(posedge clk);
    cfg_index <= REG_RUN_TIME;
    cfg_wdata <= 16'(run);
    @(posedge clk);
    cfg_index <= REG_SETTLE_TIME;
    cfg_wdata <= 16'(settle);
    @(posedge clk);
    cfg_index <= REG_TICK_PERIOD;
    cfg_wdata <= {8'd0, 8'(tick)};
    @(posedge clk);
    cfg_index <= REG_CORR_GAIN;
    cfg_wdata <= {8'd0, 8'(gain)};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_ofs = ofs;
    cfg_run = run;
    cfg_settle = settle;
    cfg_tick = tick;
  endtask

  function automatic logic [9:0] gyro_pick(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  // one start and a run of ticks: quiet, drifting or wild gyro, sometimes cut short
  task automatic play_run();
    int style, spread, center, est, len;
    est = (cfg_tick == 0) ? 40 : 8 + cfg_run / cfg_tick + cfg_settle / cfg_tick;
    len = est + $urandom_range(0, 10);
    if ($urandom_range(0, 7) == 0) len = $urandom_range(0, est);
    style = $urandom_range(0, 3);
    center = cfg_ofs;
    spread = 0;
    if (style == 0) begin
      if ($urandom_range(0, 7) == 0) spread = 3;
    end else if (style < 3) begin
      case ($urandom_range(0, 2))
        0: spread = 2;
        1: spread = 20;
        default: spread = 100;
      endcase
      center = cfg_ofs + int'($urandom_range(0, spread)) - spread / 2;
    end else begin
      spread = 1023;
    end
    if ($urandom_range(0, 39) == 0) drain_results();
    send_tick(1'b1, gyro_pick(center, spread));
    for (int i = 0; i < len; i++) begin
      if (style == 3) send_tick(1'b0, 10'($urandom_range(0, 1023)));
      else send_tick(1'b0, gyro_pick(center, spread));
    end
  endtask

  task automatic random_phase(input int budget);
    int first;
    first = ticks_sent;
    while (ticks_sent - first < budget) play_run();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle ticks at sample extremes, start, restart while driving
    send_tick(1'b0, 10'd0);
    send_tick(1'b0, 10'h3FF);
    send_tick(1'b1, 10'h3FF);
    send_tick(1'b0, 10'd0);
    send_tick(1'b1, 10'd600);
    send_tick(1'b0, 10'd600);

    // short run with full gain: drive clamps, settle, spin right crossing zero
    apply_setting(512, 100, 20, 0, 20, 255);
    send_tick(1'b1, 10'h3FF);
    send_tick(1'b0, 10'h3FF);
    send_tick(1'b0, 10'h3FF);
    send_tick(1'b0, 10'd0);
    send_tick(1'b0, 10'd0);
    send_tick(1'b0, 10'd0);
    send_tick(1'b0, 10'h3FF);

    // zero heading at decide spins left until heading goes negative
    send_tick(1'b1, 10'd512);
    send_tick(1'b0, 10'd512);
    send_tick(1'b0, 10'd512);
    send_tick(1'b0, 10'd512);
    send_tick(1'b0, 10'd512);
    send_tick(1'b0, 10'd512);
    send_tick(1'b0, 10'd511);
    send_tick(1'b0, 10'd0);

    // random runs over several register settings and stall mixes
    apply_setting(600, 50, 1000, 150, 20, 8);
    random_phase(200);
    apply_setting(0, 100, 0, 0, 1, 255);
    random_phase(150);
    stall_mix = MIX_TX_HEAVY;
    apply_setting(1023, -100, 65535, 0, 255, 0);
    random_phase(250);
    apply_setting(512, -128, 0, 65535, 255, 1);
    random_phase(250);
    stall_mix = MIX_NONE;
    apply_setting(300, 127, 100, 100, 0, 200);
    random_phase(150);
    apply_setting($urandom_range(0, 1023), int'($urandom_range(0, 200)) - 100,
                  $urandom_range(0, 400), $urandom_range(0, 400),
                  $urandom_range(5, 40), $urandom_range(0, 255));
    random_phase(200);

    // wait out the pipeline, then the verdict
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
